### hdl/tssc_pkg.sv
// package: item types and constants of the send segmentation control
`default_nettype none

package tssc_pkg;

  // bytes per data path word, as a shift
  localparam int unsigned WORD_SHIFT = 6;
  localparam int unsigned WORD_BYTES = 64;

  localparam int unsigned MAX_WORDS_W = 10;
  localparam logic [MAX_WORDS_W-1:0] MAX_WORDS_RST = 10'd16;

  // input item modes
  localparam logic MODE_CMD    = 1'b0;
  localparam logic MODE_STATUS = 1'b1;

  // result item kinds
  localparam logic KIND_REQ   = 1'b0;
  localparam logic KIND_WORDS = 1'b1;

  // status error codes
  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_TORN = 2'd1;

  // input item
  typedef struct packed {
    logic        mode;
    logic [15:0] session;
    logic [31:0] message_bytes;
    logic [15:0] granted_length;
    logic [1:0]  error_code;
  } in_item_t;

  // result item
  typedef struct packed {
    logic        kind;
    logic [15:0] out_session;
    logic [15:0] request_bytes;
    logic [10:0] word_count;
    logic        last;
  } out_item_t;

  // results caused by one input item, in order
  typedef struct packed {
    logic [1:0] num;
    out_item_t  first;
    out_item_t  second;
  } res_bundle_t;

endpackage

`default_nettype wire

### hdl/tssc_core.sv
// segmentation logic: message state and result computation for one item
`default_nettype none

module tssc_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire tssc_pkg::in_item_t                 item_i,
  input  wire logic [tssc_pkg::MAX_WORDS_W-1:0]   max_words_i,
  output tssc_pkg::res_bundle_t                   res_o
);

  logic        awaiting_q, awaiting_d;
  logic [31:0] target_q, target_d;
  logic [31:0] sent_q, sent_d;

  logic [15:0] chunk;
  logic [15:0] cmd_req;
  logic [31:0] sent_sum;
  logic        more;
  logic [32:0] reach;
  logic [31:0] remain;
  logic [15:0] next_req;
  logic [16:0] words_full;
  logic [10:0] words;

  // datapath
  assign chunk      = {max_words_i, 6'b0};
  assign cmd_req    = ({16'b0, chunk} > item_i.message_bytes) ?
                      item_i.message_bytes[15:0] : chunk;
  assign sent_sum   = sent_q + {16'b0, item_i.granted_length};
  assign more       = sent_sum < target_q;
  assign reach      = {1'b0, sent_sum} + {17'b0, chunk};
  assign remain     = target_q - sent_sum;
  assign next_req   = (reach < {1'b0, target_q}) ? chunk : remain[15:0];
  assign words_full = ({1'b0, item_i.granted_length} + 17'(tssc_pkg::WORD_BYTES - 1))
                      >> tssc_pkg::WORD_SHIFT;
  assign words      = words_full[10:0];

  // result selection and next state
  always_comb begin
    awaiting_d = awaiting_q;
    target_d   = target_q;
    sent_d     = sent_q;
    res_o      = '0;
    res_o.first.out_session  = item_i.session;
    res_o.second.out_session = item_i.session;
    if (en_i) begin
      if (!awaiting_q) begin
        if (item_i.mode == tssc_pkg::MODE_CMD) begin
          res_o.num                 = 2'd1;
          res_o.first.kind          = tssc_pkg::KIND_REQ;
          res_o.first.request_bytes = cmd_req;
          res_o.first.last          = 1'b1;
          awaiting_d = 1'b1;
          target_d   = item_i.message_bytes;
          sent_d     = '0;
        end
      end else if (item_i.mode == tssc_pkg::MODE_STATUS) begin
        if (item_i.error_code == tssc_pkg::ERR_OK) begin
          sent_d = sent_sum;
          if (more) begin
            res_o.num                 = 2'd2;
            res_o.first.kind          = tssc_pkg::KIND_REQ;
            res_o.first.request_bytes = next_req;
            res_o.first.last          = 1'b0;
            res_o.second.kind         = tssc_pkg::KIND_WORDS;
            res_o.second.word_count   = words;
            res_o.second.last         = 1'b1;
          end else begin
            res_o.num              = 2'd1;
            res_o.first.kind       = tssc_pkg::KIND_WORDS;
            res_o.first.word_count = words;
            res_o.first.last       = 1'b1;
            sent_d     = '0;
            awaiting_d = 1'b0;
          end
        end else if (item_i.error_code != tssc_pkg::ERR_TORN) begin
          // retry: ask for the same length again
          res_o.num                 = 2'd1;
          res_o.first.kind          = tssc_pkg::KIND_REQ;
          res_o.first.request_bytes = item_i.granted_length;
          res_o.first.last          = 1'b1;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      target_q   <= '0;
      sent_q     <= '0;
    end else begin
      awaiting_q <= awaiting_d;
      target_q   <= target_d;
      sent_q     <= sent_d;
    end
  end

  // a command taken while idle opens a message
  a_cmd_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && !awaiting_q && item_i.mode == tssc_pkg::MODE_CMD) |=> awaiting_q)
    else $error("command did not open a message");

  // a pair of results is always a request followed by a word count
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.num == 2'd2) |-> (res_o.first.kind == tssc_pkg::KIND_REQ &&
                             res_o.second.kind == tssc_pkg::KIND_WORDS &&
                             !res_o.first.last && res_o.second.last))
    else $error("bad result pair");

endmodule

`default_nettype wire

### hdl/tssc_fifo.sv
// result queue: takes up to two items a cycle, hands out one unless out_stall_i is high
`default_nettype none

module tssc_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tssc_pkg::res_bundle_t res_i,
  output logic                       room_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output tssc_pkg::out_item_t        out_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  tssc_pkg::out_item_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr1, wr2, rd1;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr1 = ptr_inc(wr_q);
  assign wr2 = ptr_inc(wr1);
  assign rd1 = ptr_inc(rd_q);

  // handshake side
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (count_q <= CntW'(DEPTH - 2));

  // pointers and fill level
  always_comb begin
    wr_d = wr_q;
    case (res_i.num)
      2'd1:    wr_d = wr1;
      2'd2:    wr_d = wr2;
      default: wr_d = wr_q;
    endcase
    rd_d    = pop ? rd1 : rd_q;
    count_d = count_q + CntW'(res_i.num) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (res_i.num != 2'd0 && wr_q == PtrW'(i)) begin
        mem_q[i] <= res_i.first;
      end else if (res_i.num == 2'd2 && wr1 == PtrW'(i)) begin
        mem_q[i] <= res_i.second;
      end
    end
  end

  // never overfilled
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_i.num != 2'd0) |-> ({1'b0, count_q} + (CntW + 1)'(res_i.num)
                             <= (CntW + 1)'(DEPTH)))
    else $error("result queue overflow");

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("result queue level out of range");

endmodule

`default_nettype wire

### hdl/tcp_send_segmentation_control_top.sv
// top level: tcp send segmentation control
//
//  port group  | dir | handshake              | payload
//  ------------+-----+------------------------+---------------------------
//  in          | in  | in_valid_i / in_stall_o | tssc_pkg::in_item_t
//  out         | out | out_valid_o / out_stall_i | tssc_pkg::out_item_t
//  cfg         | in  | cfg_we_i               | max words per packet
//
//  one item per cycle while in_stall_o is low; an accepted item is held in the
//  input register and its results go into the result queue once it has room;
//  a status that asks for the next chunk gives two results. sustained rate
//  is one result per cycle when unstalled, set by the single queue read port.
//  reset clears the message state and sets max words per packet to 16.
//  in_stall_o rises only when the result queue lacks room for two items.
`default_nettype none

module tcp_send_segmentation_control_top #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire tssc_pkg::in_item_t               in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output tssc_pkg::out_item_t                   out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [tssc_pkg::MAX_WORDS_W-1:0] cfg_wdata_i
);

  logic                             in_valid_q, in_valid_d;
  tssc_pkg::in_item_t               in_item_q;
  logic [tssc_pkg::MAX_WORDS_W-1:0] max_words_q;
  logic                             room;
  logic                             take;
  logic                             consume;
  tssc_pkg::res_bundle_t            res;

  // input register handshake
  assign consume    = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      max_words_q <= tssc_pkg::MAX_WORDS_RST;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) begin
        max_words_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_item_q <= in_data_i;
    end
  end

  // segmentation logic
  tssc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (consume),
    .item_i      (in_item_q),
    .max_words_i (max_words_q),
    .res_o       (res)
  );

  // result queue
  tssc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a held item is processed at once whenever the queue has room
  a_no_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && room && !take) |=> !in_valid_q)
    else $error("input item held with room available");

endmodule

`default_nettype wire

### dv/tcp_send_segmentation_control_top_test.sv
// testbench: send segmentation control against a cycle-free item-level predictor
`timescale 1ns / 100ps

module tcp_send_segmentation_control_top_test;

  // retry codes of a status item
  localparam logic [1:0] ERR_RETRY     = 2'd2;
  localparam logic [1:0] ERR_RETRY_ALT = 2'd3;

  // message state kept by the predictor
  typedef struct packed {
    logic                             msg_open;
    logic [31:0]                      target;
    logic [31:0]                      sent;
    logic [tssc_pkg::MAX_WORDS_W-1:0] max_words;
  } seg_state_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  tssc_pkg::in_item_t               in_data = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  tssc_pkg::out_item_t              out_data;
  logic                             cfg_we = 1'b0;
  logic [tssc_pkg::MAX_WORDS_W-1:0] cfg_wdata = '0;

  tssc_pkg::in_item_t    pending_items[$];
  tssc_pkg::out_item_t   expected_results[$];
  seg_state_t            gen_model;
  seg_state_t            dut_model;
  logic [15:0]           gen_last_req = '0;
  int                    gen_count = 0;
  int                    mismatches = 0;
  int                    send_idle_pct = 20;
  int                    recv_idle_pct = 20;
  int                    send_gap = 0;
  int                    recv_gap = 0;
  int                    hold_left = 0;
  logic                  pressure_phase = 1'b0;
  logic                  pressure_done = 1'b0;
  tssc_pkg::res_bundle_t accepted_res;
  tssc_pkg::out_item_t   want_res;

  tcp_send_segmentation_control_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // results that one item causes, advancing the given message state
  function automatic tssc_pkg::res_bundle_t segment_step(inout seg_state_t st,
                                                         input tssc_pkg::in_item_t it);
    tssc_pkg::res_bundle_t rb;
    tssc_pkg::out_item_t   words_res;
    logic [31:0] chunk;
    logic [31:0] remain;
    logic [32:0] reach;
    logic [16:0] gsum;
    logic [15:0] req;
    rb = '0;
    chunk = {16'd0, st.max_words, 6'd0};
    if (!st.msg_open) begin
      if (it.mode == tssc_pkg::MODE_CMD) begin
        st.target = it.message_bytes;
        st.sent = '0;
        st.msg_open = 1'b1;
        req = (chunk > it.message_bytes) ? it.message_bytes[15:0] : chunk[15:0];
        rb.num = 2'd1;
        rb.first = '{tssc_pkg::KIND_REQ, it.session, req, 11'd0, 1'b1};
      end
    end else if (it.mode == tssc_pkg::MODE_STATUS && it.error_code != tssc_pkg::ERR_TORN) begin
      if (it.error_code != tssc_pkg::ERR_OK) begin
        rb.num = 2'd1;
        rb.first = '{tssc_pkg::KIND_REQ, it.session, it.granted_length, 11'd0, 1'b1};
      end else begin
        st.sent = st.sent + {16'd0, it.granted_length};
        gsum = {1'b0, it.granted_length} + 17'(tssc_pkg::WORD_BYTES - 1);
        words_res = '{tssc_pkg::KIND_WORDS, it.session, 16'd0,
                      gsum[16:tssc_pkg::WORD_SHIFT], 1'b1};
        if (st.sent < st.target) begin
          // remaining compare is done one bit wider so it cannot wrap
          reach = {1'b0, st.sent} + {1'b0, chunk};
          remain = st.target - st.sent;
          req = (reach < {1'b0, st.target}) ? chunk[15:0] : remain[15:0];
          rb.num = 2'd2;
          rb.first = '{tssc_pkg::KIND_REQ, it.session, req, 11'd0, 1'b0};
          rb.second = words_res;
        end else begin
          rb.num = 2'd1;
          rb.first = words_res;
          st.sent = '0;
          st.msg_open = 1'b0;
        end
      end
    end
    return rb;
  endfunction

  function automatic tssc_pkg::in_item_t seg_item(logic mode, logic [15:0] sess,
                                                  logic [31:0] bytes,
                                                  logic [15:0] granted, logic [1:0] err);
    return '{mode, sess, bytes, granted, err};
  endfunction

  // queue an item and track the message it belongs to
  task automatic push_item(tssc_pkg::in_item_t it);
    tssc_pkg::res_bundle_t rb;
    rb = segment_step(gen_model, it);
    if (rb.num != 0 && rb.first.kind == tssc_pkg::KIND_REQ) gen_last_req = rb.first.request_bytes;
    pending_items.push_back(it);
    gen_count++;
  endtask

  // one whole message: command, then answers until it closes, with noise mixed in
  task automatic push_message();
    logic [31:0] chunk;
    logic [31:0] target;
    logic [15:0] sess;
    logic [15:0] ssn;
    logic [15:0] grant;
    int          pick;
    int          tries;
    chunk = {16'd0, gen_model.max_words, 6'd0};
    tries = 0;
    if ($urandom_range(0, 4) == 0)
      push_item(seg_item(tssc_pkg::MODE_STATUS, 16'($urandom), $urandom, 16'($urandom),
                         2'($urandom)));
    case ($urandom_range(0, 7))
      0:       target = '0;
      1:       target = $urandom_range(1, 64);
      default: target = $urandom_range(0, chunk * 6 + 5000);
    endcase
    sess = 16'($urandom);
    push_item(seg_item(tssc_pkg::MODE_CMD, sess, target, 16'($urandom), 2'($urandom)));
    while (gen_model.msg_open) begin
      pick = $urandom_range(0, 99);
      ssn = ($urandom_range(0, 9) == 0) ? 16'($urandom) : sess;
      if (pick < 6) begin
        push_item(seg_item(tssc_pkg::MODE_CMD, 16'($urandom), $urandom, 16'($urandom),
                           2'($urandom)));
      end else if (pick < 12) begin
        push_item(seg_item(tssc_pkg::MODE_STATUS, ssn, $urandom, 16'($urandom),
                           tssc_pkg::ERR_TORN));
      end else if (pick < 22) begin
        grant = $urandom_range(0, 1) ? gen_last_req : 16'($urandom);
        push_item(seg_item(tssc_pkg::MODE_STATUS, ssn, $urandom, grant,
                           2'($urandom_range(ERR_RETRY, ERR_RETRY_ALT))));
      end else begin
        // mostly the requested length, sometimes short or oversized
        if (tries > 40) grant = 16'hFFFF;
        else if (gen_last_req == 0)
          grant = $urandom_range(0, 3) ? 16'($urandom_range(1, 65535)) : 16'd0;
        else if (pick < 80) grant = gen_last_req;
        else if (pick < 90) grant = 16'($urandom_range(0, gen_last_req));
        else grant = 16'($urandom);
        tries++;
        push_item(seg_item(tssc_pkg::MODE_STATUS, ssn, $urandom, grant, tssc_pkg::ERR_OK));
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // register write once the block has gone quiet
  task automatic set_max_words(logic [tssc_pkg::MAX_WORDS_W-1:0] words);
    wait_drained();
    repeat (6) @(negedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= words;
    dut_model.max_words = words;
    gen_model.max_words = words;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(int count, int send_pct, int recv_pct);
    int stop;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop = gen_count + count;
    while (gen_count < stop) push_message();
  endtask

  // sender: presents queued items, with random gaps between them
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        accepted_res = segment_step(dut_model, in_data);
        if (accepted_res.num != 0) expected_results.push_back(accepted_res.first);
        if (accepted_res.num == 2) expected_results.push_back(accepted_res.second);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0 && send_idle_pct != 0 &&
                     $urandom_range(0, 99) < send_idle_pct) begin
          send_gap <= $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: one long hold-off under pressure, otherwise random bursts
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (pressure_phase && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      out_stall <= 1'b1;
    end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
      recv_gap <= $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report_field(string fname, logic [31:0] want, logic [31:0] got);
    $display("%0t: result %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    mismatches++;
  endtask

  // result checker: each accepted item against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want_res = expected_results.pop_front();
        if (out_data.kind !== want_res.kind)
          report_field("kind", 32'(want_res.kind), 32'(out_data.kind));
        if (out_data.out_session !== want_res.out_session)
          report_field("out_session", 32'(want_res.out_session), 32'(out_data.out_session));
        if (out_data.request_bytes !== want_res.request_bytes)
          report_field("request_bytes", 32'(want_res.request_bytes),
                       32'(out_data.request_bytes));
        if (out_data.word_count !== want_res.word_count)
          report_field("word_count", 32'(want_res.word_count), 32'(out_data.word_count));
        if (out_data.last !== want_res.last)
          report_field("last", 32'(want_res.last), 32'(out_data.last));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tcp_send_segmentation_control_top verification failed");
    $finish;
  end

  initial begin
    gen_model = '{1'b0, 32'd0, 32'd0, tssc_pkg::MAX_WORDS_RST};
    dut_model = gen_model;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed items under the reset packet size of 16 words
    push_item(seg_item(tssc_pkg::MODE_STATUS, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, ERR_RETRY_ALT));
    push_item(seg_item(tssc_pkg::MODE_CMD, 16'h0000, 32'd0, 16'd0, tssc_pkg::ERR_OK));
    push_item(seg_item(tssc_pkg::MODE_STATUS, 16'h0000, 32'd0, 16'd0, tssc_pkg::ERR_OK));
    push_item(seg_item(tssc_pkg::MODE_CMD, 16'hFFFF, 32'd3000, 16'hFFFF, ERR_RETRY_ALT));
    push_item(seg_item(tssc_pkg::MODE_CMD, 16'h1234, 32'hFFFF_FFFF, 16'h0000, tssc_pkg::ERR_OK));
    push_item(seg_item(tssc_pkg::MODE_STATUS, 16'hFFFF, 32'd0, 16'd1024, ERR_RETRY));
    push_item(seg_item(tssc_pkg::MODE_STATUS, 16'h00FF, 32'd0, 16'hFFFF, ERR_RETRY_ALT));
    push_item(seg_item(tssc_pkg::MODE_STATUS, 16'hFFFF, 32'd0, 16'd500, tssc_pkg::ERR_TORN));
    push_item(seg_item(tssc_pkg::MODE_STATUS, 16'hFFFF, 32'd0, 16'd1024, tssc_pkg::ERR_OK));
    push_item(seg_item(tssc_pkg::MODE_STATUS, 16'hFF00, 32'd0, 16'd1000, tssc_pkg::ERR_OK));
    push_item(seg_item(tssc_pkg::MODE_STATUS, 16'hFFFF, 32'd0, 16'd976, tssc_pkg::ERR_OK));
    push_item(seg_item(tssc_pkg::MODE_CMD, 16'h0001, 32'd1, 16'd0, tssc_pkg::ERR_OK));
    push_item(seg_item(tssc_pkg::MODE_STATUS, 16'h0001, 32'd0, 16'd1, tssc_pkg::ERR_OK));
    push_item(seg_item(tssc_pkg::MODE_CMD, 16'h0002, 32'd1024, 16'd0, tssc_pkg::ERR_OK));
    push_item(seg_item(tssc_pkg::MODE_STATUS, 16'h0002, 32'd0, 16'd1023, tssc_pkg::ERR_OK));
    push_item(seg_item(tssc_pkg::MODE_STATUS, 16'h0002, 32'd0, 16'hFFFF, tssc_pkg::ERR_OK));
    push_item(seg_item(tssc_pkg::MODE_CMD, 16'h0003, 32'd1025, 16'd0, tssc_pkg::ERR_OK));
    push_item(seg_item(tssc_pkg::MODE_STATUS, 16'h0003, 32'd0, 16'd1024, tssc_pkg::ERR_OK));
    push_item(seg_item(tssc_pkg::MODE_STATUS, 16'h0003, 32'd0, 16'd1, tssc_pkg::ERR_OK));

    // random messages over several packet sizes, extremes first
    set_max_words(10'd1);
    random_phase(350, 20, 20);
    set_max_words(10'd1023);
    random_phase(350, 0, 30);
    set_max_words(10'd0);
    random_phase(200, 25, 0);
    set_max_words(10'($urandom_range(2, 1022)));
    random_phase(300, 15, 15);
    set_max_words(10'($urandom_range(2, 1022)));
    pressure_phase = 1'b1;
    random_phase(250, 0, 10);
    set_max_words(10'($urandom_range(2, 1022)));
    random_phase(250, 30, 30);

    // closing stretch with no idling on either side
    set_max_words(10'd1023);
    random_phase(100, 0, 0);

    wait_drained();
    repeat (6) @(negedge clk);
    if (mismatches == 0) begin
      $display("tcp_send_segmentation_control_top verification clean");
    end else begin
      $display("tcp_send_segmentation_control_top verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/tssc_pkg.sv
hdl/tssc_core.sv
hdl/tssc_fifo.sv
hdl/tcp_send_segmentation_control_top.sv
dv/tcp_send_segmentation_control_top_test.sv
